// ===== rtl/core/bbc_pkg.sv =====
`default_nettype none

package bbc_pkg;

  localparam int DATA_W      = 32;
  localparam int PAIRS_W     = 3;
  localparam int PADDR_W     = 3;
  localparam int FIELD_PAIRS = 4;

  // Double dabble: a value that does not saturate is below 10**8 and fits 27 bits.
  localparam int DD_BITS   = 27;
  localparam int DD_STEPS  = 7;
  localparam int DD_STAGES = (DD_BITS + DD_STEPS - 1) / DD_STEPS;
  localparam int PROD_W    = 28;

  localparam logic [PAIRS_W-1:0] PAIRS_RESET = 3'd4;

  // Register index of digit_pairs, taken from paddr[2].
  localparam logic REG_DIGIT_PAIRS = 1'b0;

  localparam logic [DATA_W-1:0] PAIR_LIMIT [FIELD_PAIRS] =
    '{32'd99, 32'd9999, 32'd999999, 32'd99999999};
  localparam logic [PROD_W-1:0] PAIR_WEIGHT [FIELD_PAIRS] =
    '{28'd1, 28'd100, 28'd10000, 28'd1000000};

  typedef enum logic {
    FUNC_TO_BCD = 1'b0,
    FUNC_TO_BIN = 1'b1
  } func_t;

  typedef struct packed {
    func_t               func;
    logic                sat;
    logic                bad;
    logic [PAIRS_W-1:0]  pairs;
    logic [DATA_W-1:0]   operand;
  } cmd_t;

  typedef struct packed {
    func_t                              func;
    logic                               sat;
    logic                               bad;
    logic [PAIRS_W-1:0]                 pairs;
    logic [DATA_W-1:0]                  bcd;
    logic [DD_BITS-1:0]                 bin;
    logic [FIELD_PAIRS-1:0][PROD_W-1:0] prod;
  } stage_t;

endpackage

`default_nettype wire

// ===== rtl/core/binary_bcd_converter_unit.sv =====
// Path: an accepted transaction is written into the input queue, then passes through the
// pipeline stages up to the fourth; its result is on the output while the fourth stage holds it.
// Throughput: one transaction per cycle, sustained while results are popped.
// Reset (rst, synchronous): digit_pairs returns to 4, queue and pipeline empty.
`default_nettype none

module binary_bcd_converter_unit
  import bbc_pkg::*;
#(
  parameter int MAX_PAIRS   = 4,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               func,
  input  wire logic [DATA_W-1:0]  operand,
  output logic                    empty,
  input  wire logic               pop,
  output logic      [DATA_W-1:0]  result,
  output logic                    saturated,
  output logic                    invalid_digit
);

  cmd_t cmd;
  logic cmd_valid;
  cmd_t head_cmd;
  logic head_valid;
  logic back_ready;

  bbc_front #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .push      (push),
    .func      (func),
    .operand   (operand),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  bbc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_valid),
    .push_cmd   (cmd),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .take       (back_ready)
  );

  bbc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (head_valid),
    .in_cmd        (head_cmd),
    .in_ready      (back_ready),
    .empty         (empty),
    .pop           (pop),
    .result        (result),
    .saturated     (saturated),
    .invalid_digit (invalid_digit)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bbc_front.sv =====
`default_nettype none

module bbc_front
  import bbc_pkg::*;
#(
  parameter int MAX_PAIRS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  input  wire logic               push,
  input  wire logic               func,
  input  wire logic [DATA_W-1:0]  operand,
  output logic                    cmd_valid,
  output cmd_t                    cmd
);

  localparam int PAIR_TOP_RAW = (MAX_PAIRS < FIELD_PAIRS) ? MAX_PAIRS : FIELD_PAIRS;
  localparam int PAIR_TOP     = (PAIR_TOP_RAW < 1) ? 1 : PAIR_TOP_RAW;

  logic [PAIRS_W-1:0] digit_pairs;
  logic [PAIRS_W-1:0] used;
  logic [1:0]         limit_idx;
  logic [DATA_W-1:0]  masked;
  logic               bad_any;
  func_t              fsel;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIGIT_PAIRS) ? DATA_W'(digit_pairs) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_pairs <= PAIRS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DIGIT_PAIRS) begin
      digit_pairs <= pwdata[PAIRS_W-1:0];
    end
  end

  always_comb begin
    used = digit_pairs;
    if (used == '0) begin
      used = 3'd1;
    end
    if (used > PAIRS_W'(PAIR_TOP)) begin
      used = PAIRS_W'(PAIR_TOP);
    end
  end

  assign limit_idx = 2'(used - 3'd1);
  assign fsel      = func_t'(func);

  // Bytes above the used pairs are dropped; nibble check only on the kept ones.
  always_comb begin
    masked  = '0;
    bad_any = 1'b0;
    for (int k = 0; k < FIELD_PAIRS; k++) begin
      if (PAIRS_W'(k) < used) begin
        masked[8*k +: 8] = operand[8*k +: 8];
        if (operand[8*k+4 +: 4] > 4'd9 || operand[8*k +: 4] > 4'd9) begin
          bad_any = 1'b1;
        end
      end
    end
  end

  always_comb begin
    cmd.func    = fsel;
    cmd.pairs   = used;
    cmd.operand = masked;
    cmd.sat     = (fsel == FUNC_TO_BCD) && (operand > PAIR_LIMIT[limit_idx]);
    cmd.bad     = (fsel == FUNC_TO_BIN) && bad_any;
  end

  assign cmd_valid = push;

endmodule

`default_nettype wire

// ===== rtl/core/bbc_queue.sv =====
`default_nettype none

module bbc_queue
  import bbc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head_cmd,
  input  wire logic take
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_take;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entry[rd_ptr];
  assign do_push    = push && !full;
  assign do_take    = take && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_take) begin
        count <= count + 1'b1;
      end else if (do_take && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bbc_back.sv =====
`default_nettype none

module bbc_back
  import bbc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  cmd_t                   in_cmd,
  output logic                   in_ready,
  output logic                   empty,
  input  wire logic              pop,
  output logic      [DATA_W-1:0] result,
  output logic                   saturated,
  output logic                   invalid_digit
);

  localparam int LAST = DD_STAGES - 1;

  function automatic logic [DATA_W+DD_BITS-1:0] dd_run(
    input logic [DATA_W-1:0]  bcd_in,
    input logic [DD_BITS-1:0] bin_in,
    input int                 cnt
  );
    logic [DATA_W-1:0]  b;
    logic [DD_BITS-1:0] v;
    b = bcd_in;
    v = bin_in;
    for (int i = 0; i < DD_STEPS; i++) begin
      if (i < cnt) begin
        for (int j = 0; j < DATA_W / 4; j++) begin
          if (b[4*j +: 4] >= 4'd5) begin
            b[4*j +: 4] = b[4*j +: 4] + 4'd3;
          end
        end
        b = {b[DATA_W-2:0], v[DD_BITS-1]};
        v = {v[DD_BITS-2:0], 1'b0};
      end
    end
    return {b, v};
  endfunction

  function automatic logic [DATA_W-1:0] nines(input logic [PAIRS_W-1:0] n);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int k = 0; k < FIELD_PAIRS; k++) begin
      if (PAIRS_W'(k) < n) begin
        r[8*k +: 8] = 8'h99;
      end
    end
    return r;
  endfunction

  function automatic logic [PROD_W-1:0] pair_product(input logic [7:0] byte_in, input int k);
    logic [7:0] pv;
    pv = 8'({byte_in[7:4], 3'b000}) + 8'({byte_in[7:4], 1'b0}) + 8'(byte_in[3:0]);
    return PROD_W'(PROD_W'(pv) * PAIR_WEIGHT[k]);
  endfunction

  function automatic stage_t stage_eval(input stage_t d, input int g);
    stage_t                      r;
    int                          cnt;
    logic [DATA_W+DD_BITS-1:0]   dd;
    r   = d;
    cnt = DD_BITS - g * DD_STEPS;
    if (cnt > DD_STEPS) begin
      cnt = DD_STEPS;
    end
    if (d.func == FUNC_TO_BCD) begin
      dd    = dd_run(d.bcd, d.bin, cnt);
      r.bcd = dd[DATA_W+DD_BITS-1:DD_BITS];
      r.bin = dd[DD_BITS-1:0];
      if (g == LAST && d.sat) begin
        r.bcd = nines(d.pairs);
      end
    end else begin
      if (g == 0) begin
        for (int k = 0; k < FIELD_PAIRS; k++) begin
          r.prod[k] = pair_product(d.bcd[8*k +: 8], k);
        end
      end
      if (g == 1) begin
        r.bcd = (DATA_W'(d.prod[0]) + DATA_W'(d.prod[1]))
              + (DATA_W'(d.prod[2]) + DATA_W'(d.prod[3]));
      end
    end
    return r;
  endfunction

  logic   [DD_STAGES-1:0] v;
  stage_t                 d     [DD_STAGES];
  logic   [DD_STAGES:0]   rdy;
  logic   [DD_STAGES-1:0] src_v;
  stage_t                 src_d [DD_STAGES];
  stage_t                 init;

  always_comb begin
    init.func  = in_cmd.func;
    init.sat   = in_cmd.sat;
    init.bad   = in_cmd.bad;
    init.pairs = in_cmd.pairs;
    init.bcd   = (in_cmd.func == FUNC_TO_BIN) ? in_cmd.operand : '0;
    init.bin   = in_cmd.operand[DD_BITS-1:0];
    init.prod  = '0;
  end

  // A stage takes new data when it is empty or its content moves on.
  assign rdy[DD_STAGES] = pop;

  for (genvar g = 0; g < DD_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign src_v[g] = in_valid;
      assign src_d[g] = init;
    end else begin : g_rest
      assign src_v[g] = v[g-1];
      assign src_d[g] = d[g-1];
    end

    assign rdy[g] = !v[g] || rdy[g+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g] <= 1'b0;
      end else if (rdy[g]) begin
        v[g] <= src_v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g] && src_v[g]) begin
        d[g] <= stage_eval(src_d[g], g);
      end
    end
  end

  assign in_ready      = rdy[0];
  assign empty         = !v[LAST];
  assign result        = d[LAST].bcd;
  assign saturated     = d[LAST].sat;
  assign invalid_digit = d[LAST].bad;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(saturated && invalid_digit))
    else $error("saturated and invalid_digit raised together");

  a_sat_nines: assert property (@(posedge clk) disable iff (rst)
    (!empty && saturated) |-> (result[7:0] == 8'h99))
    else $error("saturated result does not hold nines in the lowest pair");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (!empty && !pop))
    else $error("pipeline stalled without a waiting result");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
  import bbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;

  localparam logic [PADDR_W-1:0] ADDR_DIGIT_PAIRS = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED    = 3'd4;

  localparam int RX_ALWAYS  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;

  typedef struct {
    func_t       func;
    logic [31:0] operand;
    logic [31:0] result;
    logic        saturated;
    logic        invalid_digit;
  } conv_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               push;
  logic               full;
  logic               func;
  logic [DATA_W-1:0]  operand;
  logic               empty;
  logic               pop;
  logic [DATA_W-1:0]  result;
  logic               saturated;
  logic               invalid_digit;

  conv_t          conv_expected[$];
  conv_t          conv_oldest;
  logic [2:0]     model_pairs = PAIRS_RESET;
  int             fail_count  = 0;
  int             burst_left  = 0;
  bit             tx_steady   = 1'b1;
  int             rx_mode     = RX_ALWAYS;
  bit             hold_request = 1'b0;
  int             hold_left   = 0;
  int unsigned    rx_cycle    = 0;
  int             stall_count = 0;

  binary_bcd_converter_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .push         (push),
    .full         (full),
    .func         (func),
    .operand      (operand),
    .empty        (empty),
    .pop          (pop),
    .result       (result),
    .saturated    (saturated),
    .invalid_digit(invalid_digit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned active_pairs(logic [2:0] pairs);
    if (pairs == 3'd0) return 1;
    if (pairs > 3'd4) return 4;
    return pairs;
  endfunction

  function automatic logic [31:0] bcd_limit(int unsigned n);
    logic [31:0] lim;
    lim = 1;
    for (int k = 0; k < 2 * n; k++) lim = lim * 10;
    return lim - 1;
  endfunction

  function automatic conv_t predict_conversion(func_t f, logic [31:0] op, logic [2:0] pairs);
    conv_t       c;
    int unsigned n;
    int unsigned hi;
    int unsigned lo;
    int unsigned weight;
    logic [31:0] value;
    logic [31:0] sum;
    n = active_pairs(pairs);
    c.func = f;
    c.operand = op;
    c.result = '0;
    c.saturated = 1'b0;
    c.invalid_digit = 1'b0;
    if (f == FUNC_TO_BCD) begin
      if (op > bcd_limit(n)) begin
        c.saturated = 1'b1;
        for (int k = 0; k < n; k++) c.result[8*k +: 8] = 8'h99;
      end else begin
        value = op;
        for (int k = 0; k < 2 * n; k++) begin
          c.result[4*k +: 4] = 4'(value % 10);
          value = value / 10;
        end
      end
    end else begin
      sum = '0;
      weight = 1;
      for (int k = 0; k < n; k++) begin
        hi = op[8*k+4 +: 4];
        lo = op[8*k +: 4];
        if (hi > 9 || lo > 9) c.invalid_digit = 1'b1;
        sum = sum + (hi * 10 + lo) * weight;
        weight = weight * 100;
      end
      c.result = sum;
    end
    return c;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Results are checked against the oldest prediction at each pop transaction.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (conv_expected.size() == 0) begin
        note_failure($sformatf("unexpected result %h sat %b bad %b", result, saturated,
                               invalid_digit));
      end else begin
        conv_oldest = conv_expected.pop_front();
        if (result !== conv_oldest.result || saturated !== conv_oldest.saturated ||
            invalid_digit !== conv_oldest.invalid_digit) begin
          note_failure($sformatf(
            "mismatch func %0d operand %h: expected %h sat %b bad %b, got %h sat %b bad %b",
            conv_oldest.func, conv_oldest.operand, conv_oldest.result,
            conv_oldest.saturated, conv_oldest.invalid_digit,
            result, saturated, invalid_digit));
        end
      end
    end
  end

  // Receiver: a long hold-off on request, otherwise the current stall pattern.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      pop <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_request <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: begin
          pop <= 1'b1;
        end
        RX_RANDOM: begin
          pop <= ($urandom_range(0, 99) < 60);
        end
        default: begin
          pop <= ((rx_cycle % 11) < 5) || ((rx_cycle % 11) == 8);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && addr[2] == REG_DIGIT_PAIRS) model_pairs = data[2:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_pairs_readback();
    logic [31:0] rdata;
    apb_access(1'b0, ADDR_DIGIT_PAIRS, '0, rdata);
    if (rdata !== {29'd0, model_pairs}) begin
      note_failure($sformatf("digit_pairs readback: expected %0d, got %h", model_pairs,
                             rdata));
    end
  endtask

  // Stops the sender and waits until every outstanding conversion has come out.
  task automatic drain_pipeline();
    push <= 1'b0;
    while (conv_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_pairs(input logic [2:0] pairs);
    logic [31:0] data;
    logic [31:0] rdata;
    drain_pipeline();
    data = $urandom();
    data[2:0] = pairs;
    apb_access(1'b1, ADDR_DIGIT_PAIRS, data, rdata);
    check_pairs_readback();
  endtask

  task automatic send_conversion(input func_t f, input logic [31:0] op);
    int gap;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 24);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    push    <= 1'b1;
    func    <= f;
    operand <= op;
    do @(posedge clk); while (full);
    conv_expected.push_back(predict_conversion(f, op, model_pairs));
  endtask

  task automatic send_random_conversion();
    int unsigned n;
    logic [31:0] lim;
    logic [31:0] op;
    n = active_pairs(model_pairs);
    lim = bcd_limit(n);
    op = $urandom();
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 5))
        0: op = $urandom_range(0, lim);
        1: op = lim;
        2: op = lim + 1;
        3: op = $urandom_range(0, 99);
        4: op = lim - $urandom_range(0, 20);
        default: ;
      endcase
      send_conversion(FUNC_TO_BCD, op);
    end else begin
      // Mostly well-formed digits in the used pairs; the upper bytes stay random.
      if ($urandom_range(0, 99) < 70) begin
        for (int k = 0; k < 2 * n; k++) op[4*k +: 4] = 4'($urandom_range(0, 9));
      end
      send_conversion(FUNC_TO_BIN, op);
    end
  endtask

  task automatic test_reset_value();
    check_pairs_readback();
  endtask

  task automatic test_directed_cases();
    logic [31:0] rdata;
    tx_steady = 1'b1;
    rx_mode = RX_ALWAYS;
    set_pairs(3'd4);
    send_conversion(FUNC_TO_BCD, 32'd0);
    send_conversion(FUNC_TO_BCD, 32'd99999999);
    send_conversion(FUNC_TO_BCD, 32'd100000000);
    send_conversion(FUNC_TO_BCD, 32'hFFFF_FFFF);
    send_conversion(FUNC_TO_BCD, 32'd12345678);
    send_conversion(FUNC_TO_BIN, 32'h9999_9999);
    send_conversion(FUNC_TO_BIN, 32'hFFFF_FFFF);
    send_conversion(FUNC_TO_BIN, 32'h0000_00A5);
    send_conversion(FUNC_TO_BIN, 32'h0000_005F);
    // A count of zero behaves as one pair.
    set_pairs(3'd0);
    send_conversion(FUNC_TO_BCD, 32'd99);
    send_conversion(FUNC_TO_BCD, 32'd100);
    send_conversion(FUNC_TO_BIN, 32'hFFFF_FF42);
    // A write to an unmapped address must leave digit_pairs alone.
    set_pairs(3'd2);
    drain_pipeline();
    apb_access(1'b1, ADDR_UNMAPPED, 32'h0000_0001, rdata);
    check_pairs_readback();
    send_conversion(FUNC_TO_BCD, 32'd9999);
    send_conversion(FUNC_TO_BCD, 32'd10000);
    send_conversion(FUNC_TO_BIN, 32'hABCD_1234);
    set_pairs(3'd3);
    send_conversion(FUNC_TO_BCD, 32'd999999);
    send_conversion(FUNC_TO_BCD, 32'd1000000);
    send_conversion(FUNC_TO_BIN, 32'h0099_9999);
    // Counts above four are clipped to four pairs.
    set_pairs(3'd7);
    send_conversion(FUNC_TO_BCD, 32'd99999999);
    send_conversion(FUNC_TO_BCD, 32'd100000000);
    send_conversion(FUNC_TO_BIN, 32'h1234_5678);
  endtask

  task automatic test_random_traffic();
    logic [2:0] phase_pairs[8] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd6, 3'd5};
    for (int p = 0; p < 8; p++) begin
      set_pairs(phase_pairs[p]);
      tx_steady = (p % 3 == 2);
      rx_mode = tx_steady ? RX_ALWAYS : ((p % 2 == 0) ? RX_RANDOM : RX_PATTERN);
      for (int i = 0; i < 110; i++) send_random_conversion();
    end
  endtask

  task automatic test_backpressure();
    set_pairs(3'd4);
    tx_steady = 1'b1;
    rx_mode = RX_ALWAYS;
    hold_request <= 1'b1;
    for (int i = 0; i < 48; i++) send_random_conversion();
    tx_steady = 1'b0;
    rx_mode = RX_RANDOM;
    for (int i = 0; i < 20; i++) send_random_conversion();
  endtask

  initial begin
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    push    <= 1'b0;
    func    <= 1'b0;
    operand <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_value();
    test_directed_cases();
    test_random_traffic();
    test_backpressure();
    drain_pipeline();
    if (fail_count == 0 && conv_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/bbc_pkg.sv
rtl/core/bbc_front.sv
rtl/core/bbc_queue.sv
rtl/core/bbc_back.sv
rtl/core/binary_bcd_converter_unit.sv
bench/tb_top.sv
